### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the symbol lookup checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define ASL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// check that cond at one edge implies prop at the next edge
`define ASL_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### src/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg
// Types, widths and table depths shared by the address symbol lookup block.
// ----------------------------------------------------------------------------
package asl_pkg;

   localparam int FUNC_DEPTH = 1024;
   localparam int LINE_DEPTH = 4096;
   localparam int FILE_DEPTH = 256;

   localparam int FUNC_AW = (FUNC_DEPTH > 1) ? $clog2(FUNC_DEPTH) : 1;
   localparam int LINE_AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int FILE_AW = (FILE_DEPTH > 1) ? $clog2(FILE_DEPTH) : 1;

   localparam int SRCH_DEPTH = (FUNC_DEPTH > LINE_DEPTH) ? FUNC_DEPTH : LINE_DEPTH;
   localparam int SRCH_CW    = $clog2(SRCH_DEPTH + 1);

   localparam int MODE_W = 2;
   localparam int ROW_W  = 12;
   localparam int ADDR_W = 64;
   localparam int NAME_W = 32;
   localparam int LINE_W = 32;
   localparam int FIDX_W = 16;

   localparam int FCNT_W = 11;
   localparam int LCNT_W = 13;
   localparam int XCNT_W = 9;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam int FUNC_ROW_W = 2 * ADDR_W + NAME_W;
   localparam int LINE_ROW_W = ADDR_W + LINE_W + FIDX_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOOKUP    = 2'd0,
      MODE_LOAD_FUNC = 2'd1,
      MODE_LOAD_LINE = 2'd2,
      MODE_LOAD_FILE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_TABLES_READY = 2'd0,
      REG_FUNC_COUNT   = 2'd1,
      REG_LINE_COUNT   = 2'd2,
      REG_FILE_COUNT   = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_FILE,
      ST_EMIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_READ,
      BS_CMP
   } bs_state_type;

   typedef struct packed {
      logic               idle;
      logic               found;
      logic [SRCH_CW-1:0] best;
   } bs_status_type;

endpackage

### src/asl_ram.sv
// ----------------------------------------------------------------------------
// asl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module asl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/asl_bisect.sv
// ----------------------------------------------------------------------------
// asl_bisect
// Iterative bisection over a sorted table: one memory read and one compare
// per step, finding the last entry at or below the key.
// ----------------------------------------------------------------------------
module asl_bisect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [asl_pkg::SRCH_CW-1:0]   count,
   input  logic [asl_pkg::ADDR_W-1:0]    key,
   output logic [asl_pkg::SRCH_CW-1:0]   rd_addr,
   input  logic [asl_pkg::ADDR_W-1:0]    rd_data,
   output asl_pkg::bs_status_type        status
);

   asl_pkg::bs_state_type state_ff, state_in;
   logic [asl_pkg::SRCH_CW-1:0] lo_ff, lo_in;
   logic [asl_pkg::SRCH_CW-1:0] hi_ff, hi_in;
   logic [asl_pkg::SRCH_CW-1:0] mid_ff, mid_in;
   logic [asl_pkg::SRCH_CW-1:0] best_ff, best_in;
   logic                        found_ff, found_in;
   logic [asl_pkg::SRCH_CW:0]   sum;
   logic [asl_pkg::SRCH_CW-1:0] mid;

   assign sum = {1'b0, lo_ff} + {1'b0, hi_ff} - {{asl_pkg::SRCH_CW{1'b0}}, 1'b1};
   assign mid = sum[asl_pkg::SRCH_CW:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asl_pkg::BS_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      best_ff <= best_in;
   end

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      best_in  = best_ff;
      found_in = found_ff;
      unique case (state_ff)
         asl_pkg::BS_IDLE: begin
            if (go) begin
               lo_in    = '0;
               hi_in    = count;
               best_in  = '0;
               found_in = 1'b0;
               state_in = asl_pkg::BS_READ;
            end
         end
         asl_pkg::BS_READ: begin
            if (lo_ff >= hi_ff) begin
               state_in = asl_pkg::BS_IDLE;
            end else begin
               mid_in   = mid;
               state_in = asl_pkg::BS_CMP;
            end
         end
         asl_pkg::BS_CMP: begin
            if (rd_data <= key) begin
               best_in  = mid_ff;
               found_in = 1'b1;
               lo_in    = mid_ff + {{(asl_pkg::SRCH_CW-1){1'b0}}, 1'b1};
            end else begin
               hi_in = mid_ff;
            end
            state_in = asl_pkg::BS_READ;
         end
         default: begin
            state_in = asl_pkg::BS_IDLE;
         end
      endcase
   end

   assign rd_addr      = mid;
   assign status.idle  = (state_ff == asl_pkg::BS_IDLE);
   assign status.found = found_ff;
   assign status.best  = best_ff;

endmodule

### src/address_symbol_lookup_core.sv
// ----------------------------------------------------------------------------
// address_symbol_lookup_core
// Function and line table lookup of a code address by bisection.
// ----------------------------------------------------------------------------
// Load items (function, line or file row) are written in the cycle they are
// accepted and never raise busy. A lookup item, while tables_ready is set,
// runs two bisection units side by side, one over the function table and one
// over the line table, each step taking a read state for its memory read and
// a compare state for its compare. After acceptance the sequencer passes
// through its search, fetch, file and emit states, and the result strobe
// comes in the emit state; busy stays high through the strobe cycle. Each
// result is shown for exactly one cycle and cannot be held off, so the
// receiver must take it in that cycle. A lookup while tables_ready is clear
// gives no result and does not raise busy. Table contents are undefined
// after reset until loaded.
// ----------------------------------------------------------------------------
module address_symbol_lookup_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [asl_pkg::MODE_W-1:0]    req_mode,
   input  logic [asl_pkg::ROW_W-1:0]     req_row_index,
   input  logic [asl_pkg::ADDR_W-1:0]    req_address,
   input  logic [asl_pkg::ADDR_W-1:0]    req_address_end,
   input  logic [asl_pkg::NAME_W-1:0]    req_name_offset,
   input  logic [asl_pkg::LINE_W-1:0]    req_line_value,
   input  logic [asl_pkg::FIDX_W-1:0]    req_file_index,
   output logic                          rsp_valid,
   output logic                          rsp_func_found,
   output logic [asl_pkg::NAME_W-1:0]    rsp_func_name_offset,
   output logic [asl_pkg::ADDR_W-1:0]    rsp_func_delta,
   output logic                          rsp_line_found,
   output logic [asl_pkg::LINE_W-1:0]    rsp_line_number,
   output logic                          rsp_file_found,
   output logic [asl_pkg::NAME_W-1:0]    rsp_file_name_offset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [asl_pkg::CSR_AW-1:0]    paddr,
   input  logic [asl_pkg::CSR_DW-1:0]    pwdata,
   output logic [asl_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   function automatic logic [31:0] clamp_cnt(input logic [31:0] n, input logic [31:0] depth);
      return (n > depth) ? depth : n;
   endfunction

   asl_pkg::ctl_state_type state_ff, state_in;

   logic                        ready_ff, ready_in;
   logic [asl_pkg::FCNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [asl_pkg::LCNT_W-1:0]  lcnt_ff, lcnt_in;
   logic [asl_pkg::XCNT_W-1:0]  xcnt_ff, xcnt_in;

   logic [asl_pkg::ADDR_W-1:0]  key_ff, key_in;
   logic                        ffound_ff, ffound_in;
   logic [asl_pkg::NAME_W-1:0]  fname_ff, fname_in;
   logic [asl_pkg::ADDR_W-1:0]  fdelta_ff, fdelta_in;
   logic                        lfound_ff, lfound_in;
   logic [asl_pkg::LINE_W-1:0]  lnum_ff, lnum_in;
   logic                        xok_ff, xok_in;

   logic                        accept;
   logic                        go;
   logic                        csr_wr;
   asl_pkg::mode_type           mode;
   asl_pkg::reg_index_type      reg_idx;

   logic                           f_we, l_we, x_we;
   logic [asl_pkg::FUNC_AW-1:0]    f_raddr;
   logic [asl_pkg::LINE_AW-1:0]    l_raddr;
   logic [asl_pkg::FILE_AW-1:0]    x_raddr;
   logic [asl_pkg::FUNC_ROW_W-1:0] f_rd;
   logic [asl_pkg::LINE_ROW_W-1:0] l_rd;
   logic [asl_pkg::NAME_W-1:0]     x_rd;

   logic [asl_pkg::ADDR_W-1:0]  f_start, f_end, l_addr;
   logic [asl_pkg::NAME_W-1:0]  f_name;
   logic [asl_pkg::LINE_W-1:0]  l_num;
   logic [asl_pkg::FIDX_W-1:0]  l_file;

   logic [asl_pkg::SRCH_CW-1:0] f_cnt, l_cnt, f_bs_addr, l_bs_addr;
   logic [31:0]                 x_cnt;
   asl_pkg::bs_status_type      f_stat, l_stat;
   logic                        line_hit;

   assign mode    = asl_pkg::mode_type'(req_mode);
   assign accept  = start & ~busy;
   assign go      = accept && (mode == asl_pkg::MODE_LOOKUP) && ready_ff;
   assign busy    = (state_ff != asl_pkg::ST_IDLE);
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign reg_idx = asl_pkg::reg_index_type'(paddr[3:2]);

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         fcnt_ff  <= '0;
         lcnt_ff  <= '0;
         xcnt_ff  <= '0;
      end else begin
         ready_ff <= ready_in;
         fcnt_ff  <= fcnt_in;
         lcnt_ff  <= lcnt_in;
         xcnt_ff  <= xcnt_in;
      end
   end

   always_comb begin
      ready_in = ready_ff;
      fcnt_in  = fcnt_ff;
      lcnt_in  = lcnt_ff;
      xcnt_in  = xcnt_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            asl_pkg::REG_TABLES_READY: ready_in = pwdata[0];
            asl_pkg::REG_FUNC_COUNT:   fcnt_in  = pwdata[asl_pkg::FCNT_W-1:0];
            asl_pkg::REG_LINE_COUNT:   lcnt_in  = pwdata[asl_pkg::LCNT_W-1:0];
            asl_pkg::REG_FILE_COUNT:   xcnt_in  = pwdata[asl_pkg::XCNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         asl_pkg::REG_TABLES_READY: prdata = 32'(ready_ff);
         asl_pkg::REG_FUNC_COUNT:   prdata = 32'(fcnt_ff);
         asl_pkg::REG_LINE_COUNT:   prdata = 32'(lcnt_ff);
         asl_pkg::REG_FILE_COUNT:   prdata = 32'(xcnt_ff);
      endcase
   end

   // table loads
   assign f_we = accept && (mode == asl_pkg::MODE_LOAD_FUNC)
                 && (32'(req_row_index) < 32'(asl_pkg::FUNC_DEPTH));
   assign l_we = accept && (mode == asl_pkg::MODE_LOAD_LINE)
                 && (32'(req_row_index) < 32'(asl_pkg::LINE_DEPTH));
   assign x_we = accept && (mode == asl_pkg::MODE_LOAD_FILE)
                 && (32'(req_row_index) < 32'(asl_pkg::FILE_DEPTH));

   asl_ram #(.WIDTH(asl_pkg::FUNC_ROW_W), .DEPTH(asl_pkg::FUNC_DEPTH)) u_func_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (asl_pkg::FUNC_AW'(req_row_index)),
      .wr_data ({req_address, req_address_end, req_name_offset}),
      .rd_addr (f_raddr),
      .rd_data (f_rd)
   );

   asl_ram #(.WIDTH(asl_pkg::LINE_ROW_W), .DEPTH(asl_pkg::LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (asl_pkg::LINE_AW'(req_row_index)),
      .wr_data ({req_address, req_line_value, req_file_index}),
      .rd_addr (l_raddr),
      .rd_data (l_rd)
   );

   asl_ram #(.WIDTH(asl_pkg::NAME_W), .DEPTH(asl_pkg::FILE_DEPTH)) u_file_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (asl_pkg::FILE_AW'(req_row_index)),
      .wr_data (req_name_offset),
      .rd_addr (x_raddr),
      .rd_data (x_rd)
   );

   assign f_start = f_rd[asl_pkg::FUNC_ROW_W-1 -: asl_pkg::ADDR_W];
   assign f_end   = f_rd[asl_pkg::NAME_W +: asl_pkg::ADDR_W];
   assign f_name  = f_rd[asl_pkg::NAME_W-1:0];
   assign l_addr  = l_rd[asl_pkg::LINE_ROW_W-1 -: asl_pkg::ADDR_W];
   assign l_num   = l_rd[asl_pkg::FIDX_W +: asl_pkg::LINE_W];
   assign l_file  = l_rd[asl_pkg::FIDX_W-1:0];

   // searches
   assign f_cnt = asl_pkg::SRCH_CW'(clamp_cnt(32'(fcnt_ff), 32'(asl_pkg::FUNC_DEPTH)));
   assign l_cnt = asl_pkg::SRCH_CW'(clamp_cnt(32'(lcnt_ff), 32'(asl_pkg::LINE_DEPTH)));
   assign x_cnt = clamp_cnt(32'(xcnt_ff), 32'(asl_pkg::FILE_DEPTH));

   asl_bisect u_func_bs (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .count   (f_cnt),
      .key     (key_ff),
      .rd_addr (f_bs_addr),
      .rd_data (f_start),
      .status  (f_stat)
   );

   asl_bisect u_line_bs (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .count   (l_cnt),
      .key     (key_ff),
      .rd_addr (l_bs_addr),
      .rd_data (l_addr),
      .status  (l_stat)
   );

   always_comb begin
      if (state_ff == asl_pkg::ST_FETCH) begin
         f_raddr = asl_pkg::FUNC_AW'(f_stat.best);
         l_raddr = asl_pkg::LINE_AW'(l_stat.best);
      end else begin
         f_raddr = asl_pkg::FUNC_AW'(f_bs_addr);
         l_raddr = asl_pkg::LINE_AW'(l_bs_addr);
      end
   end

   assign x_raddr  = asl_pkg::FILE_AW'(l_file);
   assign line_hit = l_stat.found && (l_num != '0);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      ffound_ff <= ffound_in;
      fname_ff  <= fname_in;
      fdelta_ff <= fdelta_in;
      lfound_ff <= lfound_in;
      lnum_ff   <= lnum_in;
      xok_ff    <= xok_in;
   end

   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      ffound_in = ffound_ff;
      fname_in  = fname_ff;
      fdelta_in = fdelta_ff;
      lfound_in = lfound_ff;
      lnum_in   = lnum_ff;
      xok_in    = xok_ff;
      unique case (state_ff)
         asl_pkg::ST_IDLE: begin
            if (go) begin
               key_in   = req_address;
               state_in = asl_pkg::ST_SEARCH;
            end
         end
         asl_pkg::ST_SEARCH: begin
            if (f_stat.idle && l_stat.idle) begin
               state_in = asl_pkg::ST_FETCH;
            end
         end
         asl_pkg::ST_FETCH: begin
            state_in = asl_pkg::ST_FILE;
         end
         asl_pkg::ST_FILE: begin
            ffound_in = f_stat.found && (key_ff < f_end);
            fname_in  = f_name;
            fdelta_in = key_ff - f_start;
            lfound_in = line_hit;
            lnum_in   = l_num;
            xok_in    = line_hit && (32'(l_file) < x_cnt);
            state_in  = asl_pkg::ST_EMIT;
         end
         asl_pkg::ST_EMIT: begin
            state_in = asl_pkg::ST_IDLE;
         end
         default: begin
            state_in = asl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid            = (state_ff == asl_pkg::ST_EMIT);
   assign rsp_func_found       = ffound_ff;
   assign rsp_func_name_offset = ffound_ff ? fname_ff : '0;
   assign rsp_func_delta       = ffound_ff ? fdelta_ff : '0;
   assign rsp_line_found       = lfound_ff;
   assign rsp_line_number      = lfound_ff ? lnum_ff : '0;
   assign rsp_file_found       = xok_ff;
   assign rsp_file_name_offset = xok_ff ? x_rd : '0;

endmodule

### src/asl_checker.sv
// ----------------------------------------------------------------------------
// asl_checker
// Port-level checks of the lookup sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [asl_pkg::MODE_W-1:0] req_mode,
   input logic                       rsp_valid
);

   `ASL_ASSERT(a_strobe_while_busy, clock, reset, rsp_valid |-> busy, "result strobe while not busy")
   `ASL_ASSERT_NEXT(a_idle_after_item, clock, reset, rsp_valid, !busy, "busy after result item")
   `ASL_ASSERT_NEXT(a_load_no_busy, clock, reset, start && !busy && (req_mode != asl_pkg::MODE_LOOKUP), !busy, "load item raised busy")
   `ASL_ASSERT_NEXT(a_no_instant_result, clock, reset, start && !busy, !rsp_valid, "result right after accept")
   `ASL_ASSERT(a_busy_from_accept, clock, reset, $rose(busy) |-> $past(start), "busy rose without an item")

endmodule

bind address_symbol_lookup_core asl_checker u_asl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_mode  (req_mode),
   .rsp_valid (rsp_valid)
);
